### hdl/h2r_pkg.sv
`default_nettype none
package h2r_pkg;

  localparam logic [8:0]  BrightnessReset = 9'd64;
  localparam logic [13:0] HueRecip        = 14'd11650;  // floor(2^22 / 360)
  localparam int unsigned HueRecipShift   = 22;
  localparam int unsigned HueRange        = 360;
  localparam int unsigned SectorSpan      = 60;
  localparam logic [7:0]  ChanMax         = 8'd255;

  localparam logic CmdHsv    = 1'b0;
  localparam logic CmdDirect = 1'b1;

  typedef enum logic [2:0] {
    SecRed     = 3'd0,
    SecYellow  = 3'd1,
    SecGreen   = 3'd2,
    SecCyan    = 3'd3,
    SecBlue    = 3'd4,
    SecMagenta = 3'd5
  } h2r_sector_e;

  typedef struct packed {
    logic       cmd;
    logic [2:0] led;
    logic [7:0] sat;
    logic [7:0] val;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } h2r_item_t;

  typedef struct packed {
    h2r_item_t   item;
    logic [7:0]  p;
    h2r_sector_e sector;
    logic [5:0]  rem;
  } h2r_hue_t;

  typedef struct packed {
    logic [2:0] led;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } h2r_conv_t;

  // exact floor(x / 255) for x below 65280
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = 17'(x) + 17'd1 + 17'(x[15:8]);
    return t[15:8];
  endfunction

endpackage
`default_nettype wire

### hdl/h2r_hue.sv
`default_nettype none
module h2r_hue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire h2r_pkg::h2r_item_t in_item_i,
  input  wire logic [15:0]        in_hue_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output h2r_pkg::h2r_hue_t       out_data_o
);

  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;

  assign en3 = !v3_q || out_ready_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_ready_o  = en1;
  assign out_valid_o = v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // stage 1: quotient estimate of hue / 360, v * (255 - s)
  h2r_pkg::h2r_item_t item1_q;
  logic [15:0] hue1_q;
  logic [7:0]  qe1_q, qe1_d;
  logic [15:0] pv1_q, pv1_d;
  logic [29:0] hq;

  always_comb begin
    hq    = 30'(in_hue_i) * 30'(h2r_pkg::HueRecip);
    qe1_d = hq[29:h2r_pkg::HueRecipShift];
    pv1_d = 16'(in_item_i.val) * 16'(h2r_pkg::ChanMax - in_item_i.sat);
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      item1_q <= in_item_i;
      hue1_q  <= in_hue_i;
      qe1_q   <= qe1_d;
      pv1_q   <= pv1_d;
    end
  end

  // stage 2: hue mod 360 with one correction, p
  h2r_pkg::h2r_item_t item2_q;
  logic [8:0]  h2_q, h2_d;
  logic [7:0]  p2_q;
  logic [16:0] hr;

  always_comb begin
    hr = {1'b0, hue1_q} - 17'(qe1_q) * 17'(h2r_pkg::HueRange);
    if (hr >= 17'(h2r_pkg::HueRange)) begin
      h2_d = 9'(hr - 17'(h2r_pkg::HueRange));
    end else begin
      h2_d = hr[8:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      item2_q <= item1_q;
      h2_q    <= h2_d;
      p2_q    <= h2r_pkg::div255(pv1_q);
    end
  end

  // stage 3: sector and remainder within it
  h2r_pkg::h2r_sector_e sec_d;
  logic [8:0] base;

  always_comb begin
    if (h2_q >= 9'(5 * h2r_pkg::SectorSpan)) begin
      sec_d = h2r_pkg::SecMagenta;
      base  = 9'(5 * h2r_pkg::SectorSpan);
    end else if (h2_q >= 9'(4 * h2r_pkg::SectorSpan)) begin
      sec_d = h2r_pkg::SecBlue;
      base  = 9'(4 * h2r_pkg::SectorSpan);
    end else if (h2_q >= 9'(3 * h2r_pkg::SectorSpan)) begin
      sec_d = h2r_pkg::SecCyan;
      base  = 9'(3 * h2r_pkg::SectorSpan);
    end else if (h2_q >= 9'(2 * h2r_pkg::SectorSpan)) begin
      sec_d = h2r_pkg::SecGreen;
      base  = 9'(2 * h2r_pkg::SectorSpan);
    end else if (h2_q >= 9'(h2r_pkg::SectorSpan)) begin
      sec_d = h2r_pkg::SecYellow;
      base  = 9'(h2r_pkg::SectorSpan);
    end else begin
      sec_d = h2r_pkg::SecRed;
      base  = 9'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      out_data_o.item   <= item2_q;
      out_data_o.p      <= p2_q;
      out_data_o.sector <= sec_d;
      out_data_o.rem    <= 6'(h2_q - base);
    end
  end

endmodule
`default_nettype wire

### hdl/h2r_chan.sv
`default_nettype none
module h2r_chan (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire h2r_pkg::h2r_hue_t in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output h2r_pkg::h2r_conv_t     out_data_o
);

  logic v4_q, v5_q, v6_q, v7_q;
  logic en4, en5, en6, en7;

  assign en7 = !v7_q || out_ready_i;
  assign en6 = !v6_q || en7;
  assign en5 = !v5_q || en6;
  assign en4 = !v4_q || en5;
  assign in_ready_o  = en4;
  assign out_valid_o = v7_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else begin
      if (en4) v4_q <= in_valid_i;
      if (en5) v5_q <= v4_q;
      if (en6) v6_q <= v5_q;
      if (en7) v7_q <= v6_q;
    end
  end

  // stage 4: f = rem * 255 / 60 = rem * 17 / 4, s*f and s*(255-f)
  h2r_pkg::h2r_item_t   item4_q;
  logic [7:0]           p4_q;
  h2r_pkg::h2r_sector_e sec4_q;
  logic [15:0]          sf4_q, sg4_q;
  logic [9:0]           f17;
  logic [7:0]           f;

  always_comb begin
    f17 = 10'(in_data_i.rem) * 10'd17;
    f   = f17[9:2];
  end

  always_ff @(posedge clk_i) begin
    if (en4 && in_valid_i) begin
      item4_q <= in_data_i.item;
      p4_q    <= in_data_i.p;
      sec4_q  <= in_data_i.sector;
      sf4_q   <= 16'(in_data_i.item.sat) * 16'(f);
      sg4_q   <= 16'(in_data_i.item.sat) * 16'(h2r_pkg::ChanMax - f);
    end
  end

  // stage 5: 255 - s*f/255 and 255 - s*(255-f)/255
  h2r_pkg::h2r_item_t   item5_q;
  logic [7:0]           p5_q, a5_q, b5_q;
  h2r_pkg::h2r_sector_e sec5_q;

  always_ff @(posedge clk_i) begin
    if (en5 && v4_q) begin
      item5_q <= item4_q;
      p5_q    <= p4_q;
      sec5_q  <= sec4_q;
      a5_q    <= h2r_pkg::ChanMax - h2r_pkg::div255(sf4_q);
      b5_q    <= h2r_pkg::ChanMax - h2r_pkg::div255(sg4_q);
    end
  end

  // stage 6: v * a, v * b
  h2r_pkg::h2r_item_t   item6_q;
  logic [7:0]           p6_q;
  h2r_pkg::h2r_sector_e sec6_q;
  logic [15:0]          va6_q, vb6_q;

  always_ff @(posedge clk_i) begin
    if (en6 && v5_q) begin
      item6_q <= item5_q;
      p6_q    <= p5_q;
      sec6_q  <= sec5_q;
      va6_q   <= 16'(item5_q.val) * 16'(a5_q);
      vb6_q   <= 16'(item5_q.val) * 16'(b5_q);
    end
  end

  // stage 7: q, t and sector select
  logic [7:0] q, t, v, p;
  logic [7:0] r_d, g_d, b_d;

  always_comb begin
    q = h2r_pkg::div255(va6_q);
    t = h2r_pkg::div255(vb6_q);
    v = item6_q.val;
    p = p6_q;
    case (sec6_q)
      h2r_pkg::SecRed:    begin r_d = v; g_d = t; b_d = p; end
      h2r_pkg::SecYellow: begin r_d = q; g_d = v; b_d = p; end
      h2r_pkg::SecGreen:  begin r_d = p; g_d = v; b_d = t; end
      h2r_pkg::SecCyan:   begin r_d = p; g_d = q; b_d = v; end
      h2r_pkg::SecBlue:   begin r_d = t; g_d = p; b_d = v; end
      default:            begin r_d = v; g_d = p; b_d = q; end
    endcase
    if (item6_q.cmd == h2r_pkg::CmdDirect) begin
      r_d = item6_q.red;
      g_d = item6_q.green;
      b_d = item6_q.blue;
    end else if (item6_q.sat == 8'd0) begin
      r_d = v;
      g_d = v;
      b_d = v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en7 && v6_q) begin
      out_data_o.led   <= item6_q.led;
      out_data_o.red   <= r_d;
      out_data_o.green <= g_d;
      out_data_o.blue  <= b_d;
    end
  end

endmodule
`default_nettype wire

### hdl/h2r_scale.sv
`default_nettype none
module h2r_scale (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [8:0]         brightness_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire h2r_pkg::h2r_conv_t in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output h2r_pkg::h2r_conv_t      out_conv_o,
  output logic [23:0]             out_word_o
);

  logic v8_q, v9_q;
  logic en8, en9;

  assign en9 = !v9_q || out_ready_i;
  assign en8 = !v8_q || en9;
  assign in_ready_o  = en8;
  assign out_valid_o = v9_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v8_q <= 1'b0;
      v9_q <= 1'b0;
    end else begin
      if (en8) v8_q <= in_valid_i;
      if (en9) v9_q <= v8_q;
    end
  end

  // stage 8: channel * gain
  h2r_pkg::h2r_conv_t conv8_q;
  logic [16:0] pr8_q, pg8_q, pb8_q;

  always_ff @(posedge clk_i) begin
    if (en8 && in_valid_i) begin
      conv8_q <= in_data_i;
      pr8_q   <= 17'(in_data_i.red)   * 17'(brightness_i);
      pg8_q   <= 17'(in_data_i.green) * 17'(brightness_i);
      pb8_q   <= 17'(in_data_i.blue)  * 17'(brightness_i);
    end
  end

  // stage 9: drop the fraction, clamp, pack
  function automatic logic [7:0] clamp8(input logic [16:0] x);
    return x[16] ? h2r_pkg::ChanMax : x[15:8];
  endfunction

  always_ff @(posedge clk_i) begin
    if (en9 && v8_q) begin
      out_conv_o <= conv8_q;
      out_word_o <= {clamp8(pr8_q), clamp8(pg8_q), clamp8(pb8_q)};
    end
  end

endmodule
`default_nettype wire

### hdl/hsv_to_rgb_led_word_top.sv
`default_nettype none
// Channel  Dir  Handshake                    Payload
// s_axis   in   s_axis_tvalid/s_axis_tready  tuser cmd, tdata 64 bits
// m_axis   out  m_axis_tvalid/m_axis_tready  tdata 56 bits
// cfg      in   cfg_valid/cfg_ready          cfg_data brightness, 9 bits
//
// One request per clock sustained while m_axis_tready stays high.
// Each request passes through nine register stages: two for hue reduction, sector split,
// three multiply/divide-by-255 steps, channel select, gain multiply, clamp/pack.
// Reset clears all valid bits and loads brightness 64; cfg_ready is always high.
// Each stage holds while the one after it is full and stalled; bubbles collapse.
module hsv_to_rgb_led_word_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // led_index, hue, saturation,
                                           // brightness_value, red_in, green_in,
                                           // blue_in
  input  wire logic        s_axis_tuser,   // cmd
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [55:0]      m_axis_tdata,   // led_index_out, led_word, conv_red,
                                           // conv_green, conv_blue
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [8:0]  cfg_data        // brightness
);

  logic [8:0] brightness_q;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brightness_q <= h2r_pkg::BrightnessReset;
    end else if (cfg_valid) begin
      brightness_q <= cfg_data;
    end
  end

  h2r_pkg::h2r_item_t in_item;
  logic [15:0]        in_hue;

  always_comb begin
    in_item.cmd   = s_axis_tuser;
    in_item.led   = s_axis_tdata[2:0];
    in_hue        = s_axis_tdata[18:3];
    in_item.sat   = s_axis_tdata[26:19];
    in_item.val   = s_axis_tdata[34:27];
    in_item.red   = s_axis_tdata[42:35];
    in_item.green = s_axis_tdata[50:43];
    in_item.blue  = s_axis_tdata[58:51];
  end

  logic               hue_valid, hue_ready;
  h2r_pkg::h2r_hue_t  hue_data;
  logic               conv_valid, conv_ready;
  h2r_pkg::h2r_conv_t conv_data;
  h2r_pkg::h2r_conv_t out_conv;
  logic [23:0]        out_word;

  h2r_hue u_hue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_item_i   (in_item),
    .in_hue_i    (in_hue),
    .out_valid_o (hue_valid),
    .out_ready_i (hue_ready),
    .out_data_o  (hue_data)
  );

  h2r_chan u_chan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (hue_valid),
    .in_ready_o  (hue_ready),
    .in_data_i   (hue_data),
    .out_valid_o (conv_valid),
    .out_ready_i (conv_ready),
    .out_data_o  (conv_data)
  );

  h2r_scale u_scale (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .brightness_i (brightness_q),
    .in_valid_i   (conv_valid),
    .in_ready_o   (conv_ready),
    .in_data_i    (conv_data),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_conv_o   (out_conv),
    .out_word_o   (out_word)
  );

  assign m_axis_tdata = {5'd0, out_conv.blue, out_conv.green, out_conv.red,
                         out_word, out_conv.led};

endmodule
`default_nettype wire

### tb/tb_hsv_to_rgb_led_word_top.sv
`timescale 1ns / 1ps
module tb_hsv_to_rgb_led_word_top;

  localparam int unsigned IdleLimit = 1000;
  localparam int unsigned SettleCycles = 12;
  localparam int unsigned PhaseItems = 117;
  localparam int unsigned ReportMax = 10;

  typedef struct {
    logic       cmd;
    logic [2:0] led;
    logic [15:0] hue;
    logic [7:0] sat;
    logic [7:0] val;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct {
    logic [2:0]  led;
    logic [23:0] word;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } led_out_t;

  typedef struct {
    pixel_t   px;
    bit       typed;
    led_out_t want;
  } pixel_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [55:0] m_axis_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [8:0]  cfg_data;

  led_out_t    pending_words[$];
  logic [8:0]  gain_now;
  bit          steady_flow;
  int unsigned failures;
  int unsigned idle_cycles;

  hsv_to_rgb_led_word_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [7:0] apply_gain(logic [7:0] c, logic [8:0] gain);
    logic [16:0] prod;
    prod = 17'(c) * 17'(gain);
    return (prod[16:8] > 9'(h2r_pkg::ChanMax)) ? h2r_pkg::ChanMax : prod[15:8];
  endfunction

  function automatic led_out_t convert_pixel(pixel_t px, logic [8:0] gain);
    led_out_t             o;
    int unsigned          h, f, s, v, p, q, t;
    logic [7:0]           r, g, b;
    h2r_pkg::h2r_sector_e sec;
    s = px.sat;
    v = px.val;
    if (px.cmd == h2r_pkg::CmdDirect) begin
      r = px.red;
      g = px.green;
      b = px.blue;
    end else if (s == 0) begin
      r = 8'(v);
      g = 8'(v);
      b = 8'(v);
    end else begin
      h = px.hue % h2r_pkg::HueRange;
      sec = h2r_pkg::h2r_sector_e'(h / h2r_pkg::SectorSpan);
      f = (h % h2r_pkg::SectorSpan) * 255 / h2r_pkg::SectorSpan;
      p = v * (255 - s) / 255;
      q = v * (255 - s * f / 255) / 255;
      t = v * (255 - s * (255 - f) / 255) / 255;
      case (sec)
        h2r_pkg::SecRed: begin
          r = 8'(v); g = 8'(t); b = 8'(p);
        end
        h2r_pkg::SecYellow: begin
          r = 8'(q); g = 8'(v); b = 8'(p);
        end
        h2r_pkg::SecGreen: begin
          r = 8'(p); g = 8'(v); b = 8'(t);
        end
        h2r_pkg::SecCyan: begin
          r = 8'(p); g = 8'(q); b = 8'(v);
        end
        h2r_pkg::SecBlue: begin
          r = 8'(t); g = 8'(p); b = 8'(v);
        end
        default: begin
          r = 8'(v); g = 8'(p); b = 8'(q);
        end
      endcase
    end
    o.led = px.led;
    o.red = r;
    o.green = g;
    o.blue = b;
    o.word = {apply_gain(r, gain), apply_gain(g, gain), apply_gain(b, gain)};
    return o;
  endfunction

  // unused fields get random content, the block must ignore them
  function automatic pixel_t direct_px(logic [2:0] led, logic [7:0] r, logic [7:0] g,
                                       logic [7:0] b);
    pixel_t px;
    px.cmd = h2r_pkg::CmdDirect;
    px.led = led;
    px.hue = 16'($urandom);
    px.sat = 8'($urandom);
    px.val = 8'($urandom);
    px.red = r;
    px.green = g;
    px.blue = b;
    return px;
  endfunction

  function automatic pixel_t hsv_px(logic [2:0] led, logic [15:0] hue, logic [7:0] s,
                                    logic [7:0] v);
    pixel_t px;
    px.cmd = h2r_pkg::CmdHsv;
    px.led = led;
    px.hue = hue;
    px.sat = s;
    px.val = v;
    px.red = 8'($urandom);
    px.green = 8'($urandom);
    px.blue = 8'($urandom);
    return px;
  endfunction

  // entered and left at a falling edge
  task automatic send_pixel(pixel_t px, bit typed, led_out_t want);
    int unsigned gap;
    gap = steady_flow ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= px.cmd;
    s_axis_tdata  <= {5'd0, px.blue, px.green, px.red, px.val, px.sat, px.hue, px.led};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_words.push_back(typed ? want : convert_pixel(px, gain_now));
    @(negedge clk_i);
  endtask

  task automatic check_led_word(logic [55:0] beat);
    led_out_t got, want;
    got.led   = beat[2:0];
    got.word  = beat[26:3];
    got.red   = beat[34:27];
    got.green = beat[42:35];
    got.blue  = beat[50:43];
    if (pending_words.size() == 0) begin
      failures++;
      if (failures <= ReportMax)
        $display("unrequested result: led=%0d word=%06h", got.led, got.word);
    end else begin
      want = pending_words.pop_front();
      if (got.led !== want.led || got.word !== want.word || got.red !== want.red ||
          got.green !== want.green || got.blue !== want.blue) begin
        failures++;
        if (failures <= ReportMax)
          $display({"mismatch: want led=%0d word=%06h rgb=%02h_%02h_%02h, ",
                    "got led=%0d word=%06h rgb=%02h_%02h_%02h"},
                   want.led, want.word, want.red, want.green, want.blue,
                   got.led, got.word, got.red, got.green, got.blue);
      end
    end
  endtask

  // result side
  initial begin
    int unsigned stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, 8);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      check_led_word(m_axis_tdata);
      @(negedge clk_i);
    end
  end

  // stall watchdog
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("CHECK FAILED");
        $finish;
      end else begin
        idle_cycles++;
      end
    end
  end

  initial begin
    pixel_row_t  directed[$];
    pixel_t      px;
    led_out_t    none_given;
    logic [8:0]  gain_plan[$];
    logic [8:0]  g;
    int unsigned p, n;

    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    rst_ni        = 1'b0;
    steady_flow   = 1'b0;
    failures      = 0;
    gain_now      = h2r_pkg::BrightnessReset;
    none_given    = '{default: '0};

    // typed rows assume the reset gain of 64
    directed.push_back('{direct_px(3'd7, 8'hFF, 8'h00, 8'h80), 1'b1,
                         '{3'd7, 24'h3F0020, 8'hFF, 8'h00, 8'h80}});
    directed.push_back('{direct_px(3'd0, 8'h00, 8'h00, 8'h00), 1'b1,
                         '{3'd0, 24'h000000, 8'h00, 8'h00, 8'h00}});
    directed.push_back('{direct_px(3'd5, 8'hFF, 8'hFF, 8'hFF), 1'b1,
                         '{3'd5, 24'h3F3F3F, 8'hFF, 8'hFF, 8'hFF}});
    directed.push_back('{hsv_px(3'd1, 16'd1234, 8'd0, 8'd200), 1'b1,
                         '{3'd1, 24'h323232, 8'hC8, 8'hC8, 8'hC8}});
    directed.push_back('{hsv_px(3'd2, 16'd0, 8'd255, 8'd255), 1'b1,
                         '{3'd2, 24'h3F0000, 8'hFF, 8'h00, 8'h00}});
    directed.push_back('{hsv_px(3'd3, 16'd120, 8'd255, 8'd255), 1'b1,
                         '{3'd3, 24'h003F00, 8'h00, 8'hFF, 8'h00}});
    directed.push_back('{hsv_px(3'd4, 16'd240, 8'd255, 8'd255), 1'b1,
                         '{3'd4, 24'h00003F, 8'h00, 8'h00, 8'hFF}});
    directed.push_back('{hsv_px(3'd6, 16'd360, 8'd255, 8'd255), 1'b1,
                         '{3'd6, 24'h3F0000, 8'hFF, 8'h00, 8'h00}});
    directed.push_back('{hsv_px(3'd0, 16'd77, 8'd255, 8'd0), 1'b1,
                         '{3'd0, 24'h000000, 8'h00, 8'h00, 8'h00}});
    directed.push_back('{hsv_px(3'd1, 16'hFFFF, 8'd0, 8'd255), 1'b1,
                         '{3'd1, 24'h3F3F3F, 8'hFF, 8'hFF, 8'hFF}});
    directed.push_back('{hsv_px(3'd7, 16'hFFFF, 8'd255, 8'd255), 1'b0, none_given});
    directed.push_back('{hsv_px(3'd1, 16'd59, 8'd200, 8'd180), 1'b0, none_given});
    directed.push_back('{hsv_px(3'd2, 16'd60, 8'd200, 8'd180), 1'b0, none_given});
    directed.push_back('{hsv_px(3'd3, 16'd119, 8'd128, 8'd255), 1'b0, none_given});
    directed.push_back('{hsv_px(3'd4, 16'd179, 8'd1, 8'd255), 1'b0, none_given});
    directed.push_back('{hsv_px(3'd5, 16'd180, 8'd255, 8'd1), 1'b0, none_given});
    directed.push_back('{hsv_px(3'd6, 16'd299, 8'd90, 8'd200), 1'b0, none_given});
    directed.push_back('{hsv_px(3'd7, 16'd300, 8'd255, 8'd255), 1'b0, none_given});
    directed.push_back('{hsv_px(3'd0, 16'd359, 8'd255, 8'd255), 1'b0, none_given});
    directed.push_back('{hsv_px(3'd2, 16'd60, 8'd255, 8'd255), 1'b0, none_given});
    directed.push_back('{hsv_px(3'd5, 16'd65519, 8'd37, 8'd222), 1'b0, none_given});

    gain_plan = '{9'd256, 9'd0, 9'd511, 9'd257, 9'd1, 9'd255, 9'd128, 9'd64};
    gain_plan.push_back(9'($urandom_range(2, 510)));

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed[i]) send_pixel(directed[i].px, directed[i].typed, directed[i].want);

    for (p = 0; p < gain_plan.size(); p++) begin
      // hold off until the pipe is empty before touching the gain
      s_axis_tvalid <= 1'b0;
      while (pending_words.size() != 0) @(negedge clk_i);
      repeat (SettleCycles) @(negedge clk_i);
      g = gain_plan[p];
      cfg_valid <= 1'b1;
      cfg_data  <= g;
      @(posedge clk_i);
      while (!cfg_ready) @(posedge clk_i);
      gain_now = g;
      @(negedge clk_i);
      cfg_valid <= 1'b0;
      steady_flow = (p % 3 == 1);

      for (n = 0; n < (PhaseItems * 8) / gain_plan.size(); n++) begin
        px.cmd   = ($urandom_range(0, 3) == 0) ? h2r_pkg::CmdDirect : h2r_pkg::CmdHsv;
        px.led   = 3'($urandom);
        px.red   = 8'($urandom);
        px.green = 8'($urandom);
        px.blue  = 8'($urandom);
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: px.hue = 16'($urandom_range(0, h2r_pkg::HueRange - 1));
          6, 7:             px.hue = 16'($urandom);
          8:                px.hue = 16'(h2r_pkg::SectorSpan * $urandom_range(0, 1091) +
                                         ($urandom_range(0, 1) ?
                                          h2r_pkg::SectorSpan - 1 : 0));
          default:          px.hue = 16'hFFFF - 16'($urandom_range(0, 400));
        endcase
        case ($urandom_range(0, 7))
          0:       px.sat = 8'd0;
          1:       px.sat = h2r_pkg::ChanMax;
          default: px.sat = 8'($urandom);
        endcase
        case ($urandom_range(0, 7))
          0:       px.val = 8'd0;
          1:       px.val = h2r_pkg::ChanMax;
          default: px.val = 8'($urandom);
        endcase
        send_pixel(px, 1'b0, none_given);
      end
    end

    s_axis_tvalid <= 1'b0;
    steady_flow = 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (failures == 0 && pending_words.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/h2r_pkg.sv
hdl/h2r_hue.sv
hdl/h2r_chan.sv
hdl/h2r_scale.sv
hdl/hsv_to_rgb_led_word_top.sv
tb/tb_hsv_to_rgb_led_word_top.sv
